// File: hdl/pt_pkg.sv
// pt_pkg: shared types, constants and codes of the presence table with aging
// no dependencies; imported by every module of the block

package pt_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int ID_W         = 16;
   localparam int STAMP_W      = 32;
   localparam int KIND_W       = 3;
   localparam int REQ_DATA_W   = ID_W + STAMP_W;
   localparam int RSP_DATA_W   = ID_W;

   // register port
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_INDEX_W = CSR_ADDR_W - 2;
   localparam logic [CSR_INDEX_W-1:0] REG_ABSENCE_LIMIT = '0;
   localparam logic [STAMP_W-1:0]     LIMIT_RESET       = 32'd30;

   // request operations
   localparam logic OP_DETECT = 1'b0;
   localparam logic OP_CHECK  = 1'b1;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_UPDATED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FULL    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ABSENT  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DONE    = 3'd4;

   typedef logic [ID_W-1:0]    id_type;
   typedef logic [STAMP_W-1:0] stamp_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic shift;      // take the neighbor's entry
      logic load_id;    // take the id from the shared bus
      logic load_seen;  // take the time from the shared bus
   } pt_cell_ctrl_type;

endpackage

// File: hdl/pt_cell.sv
// pt_cell: one table slot holding a device id and its last-seen time
// depends on pt_pkg; shifts toward the head or loads from the shared bus

module pt_cell (
   input  logic                      clock,
   input  pt_pkg::pt_cell_ctrl_type  ctrl,
   input  pt_pkg::id_type            next_id,
   input  pt_pkg::stamp_type         next_seen,
   input  pt_pkg::id_type            bus_id,
   input  pt_pkg::stamp_type         bus_seen,
   output pt_pkg::id_type            id,
   output pt_pkg::stamp_type         seen,
   output logic                      hit
);
   import pt_pkg::*;

   id_type    id_ff, id_in;
   stamp_type seen_ff, seen_in;

   // bus load wins over the shift from the neighbor
   always_comb begin
      id_in   = id_ff;
      seen_in = seen_ff;
      if (ctrl.load_id) begin
         id_in = bus_id;
      end else if (ctrl.shift) begin
         id_in = next_id;
      end
      if (ctrl.load_seen) begin
         seen_in = bus_seen;
      end else if (ctrl.shift) begin
         seen_in = next_seen;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      seen_ff <= seen_in;
   end

   // id compare against the bus for detect lookups
   assign hit  = (id_ff == bus_id);
   assign id   = id_ff;
   assign seen = seen_ff;

endmodule

// File: hdl/presence_table_with_aging.sv
// presence_table_with_aging: top level with the cell row, sequencer and register port
// depends on pt_pkg and pt_cell

// Keeps up to TABLE_DEPTH device ids in arrival order, each in a cell of a row,
// with its last-seen time. A detect request (tuser 0): all cells compare their id
// at once, the matching cell takes the new time, or the first free cell takes the
// new entry (nothing is stored when the row is full), and one response follows. A
// check request (tuser 1) walks the row through the head cell: every cycle, while
// the output register is free or being emptied, the row shifts one place toward
// the head, the head entry is aged against absence_limit, and a survivor is
// written back behind the last entry while an aged-out one is reported and
// dropped. A check thus goes through acceptance, one step per entry and a closing
// done response. A new request is taken once the previous one has put out its
// last response into the output register and that register is free or being
// emptied. No clearing is needed after reset.

module presence_table_with_aging (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pt_pkg::REQ_DATA_W-1:0]     req_tdata,   // dev_id, timestamp
   input  logic                              req_tuser,   // operation
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pt_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // reported_id
   output logic [pt_pkg::KIND_W-1:0]         rsp_tuser,   // kind
   output logic                              rsp_tlast,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pt_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pt_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pt_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                              csr_pready
);
   import pt_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   // request fields
   id_type    req_id;
   stamp_type req_stamp;
   assign req_id    = req_tdata[ID_W-1:0];
   assign req_stamp = req_tdata[REQ_DATA_W-1:ID_W];

   // control state
   logic             state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] remaining_ff, remaining_in;
   stamp_type        now_ff, now_in;
   stamp_type        limit_ff, limit_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   id_type            rsp_id_ff, rsp_id_in;
   logic              rsp_last_ff, rsp_last_in;

   // cell row
   pt_cell_ctrl_type        cell_ctrl [TABLE_DEPTH];
   id_type                  cell_id   [TABLE_DEPTH];
   stamp_type               cell_seen [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  cell_hit;
   logic [TABLE_DEPTH-1:0]  match_vec;
   id_type                  bus_id;
   stamp_type               bus_seen;

   logic out_free, req_fire, detect_go, check_go, step, expired, hit_any, full;
   logic [CNT_W-1:0] tail_pos;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign detect_go  = req_fire && (req_tuser == OP_DETECT);
   assign check_go   = req_fire && (req_tuser == OP_CHECK);
   assign step       = (state_ff == ST_SCAN) && (remaining_ff != '0) && out_free;
   assign full       = (count_ff == CNT_W'(TABLE_DEPTH));
   assign tail_pos   = count_ff - CNT_W'(1);
   assign expired    = (now_ff - cell_seen[0]) > limit_ff;
   assign hit_any    = |match_vec;

   // shared bus: the head entry while scanning, else the request
   always_comb begin
      bus_id   = req_id;
      bus_seen = req_stamp;
      if (state_ff == ST_SCAN) begin
         bus_id   = cell_id[0];
         bus_seen = cell_seen[0];
      end
   end

   // hits only count inside the occupied part of the row
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match_vec[i] = cell_hit[i] && (CNT_W'(i) < count_ff);
      end
   end

   // per-cell control
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         cell_ctrl[i] = '0;
         if (detect_go) begin
            if (hit_any) begin
               cell_ctrl[i].load_seen = match_vec[i];
            end else if (!full) begin
               cell_ctrl[i].load_id   = (CNT_W'(i) == count_ff);
               cell_ctrl[i].load_seen = (CNT_W'(i) == count_ff);
            end
         end
         if (step) begin
            cell_ctrl[i].shift = 1'b1;
            if (!expired && (CNT_W'(i) == tail_pos)) begin
               cell_ctrl[i].load_id   = 1'b1;
               cell_ctrl[i].load_seen = 1'b1;
            end
         end
      end
   end

   // row of cells, each fed by its neighbor toward the tail
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      id_type    nb_id;
      stamp_type nb_seen;
      if (g == TABLE_DEPTH - 1) begin : g_tail
         assign nb_id   = cell_id[g];
         assign nb_seen = cell_seen[g];
      end else begin : g_body
         assign nb_id   = cell_id[g+1];
         assign nb_seen = cell_seen[g+1];
      end
      pt_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[g]),
         .next_id   (nb_id),
         .next_seen (nb_seen),
         .bus_id    (bus_id),
         .bus_seen  (bus_seen),
         .id        (cell_id[g]),
         .seen      (cell_seen[g]),
         .hit       (cell_hit[g])
      );
   end

   // sequencer, counters and output register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remaining_in = remaining_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;

      if (detect_go) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = req_id;
         rsp_last_in  = 1'b1;
         if (hit_any) begin
            rsp_kind_in = KIND_UPDATED;
         end else if (!full) begin
            rsp_kind_in = KIND_ADDED;
            count_in    = count_ff + CNT_W'(1);
         end else begin
            rsp_kind_in = KIND_FULL;
         end
      end

      if (check_go) begin
         state_in     = ST_SCAN;
         remaining_in = count_ff;
         now_in       = req_stamp;
      end

      if (step) begin
         remaining_in = remaining_ff - CNT_W'(1);
         if (expired) begin
            count_in     = count_ff - CNT_W'(1);
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_ABSENT;
            rsp_id_in    = cell_id[0];
            rsp_last_in  = 1'b0;
         end
      end

      // closing response of a check
      if ((state_ff == ST_SCAN) && (remaining_ff == '0) && out_free) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_DONE;
         rsp_id_in    = '0;
         rsp_last_in  = 1'b1;
      end
   end

   // absence limit register
   logic csr_write;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr[CSR_ADDR_W-1:2] == REG_ABSENCE_LIMIT);

   always_comb begin
      limit_in = limit_ff;
      if (csr_write) begin
         limit_in = csr_pwdata;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_ABSENCE_LIMIT) ? limit_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: hdl/pt_checker.sv
// pt_checker: port-level assertions for presence_table_with_aging
// depends on pt_pkg; attached to the top level by the bind at the end

module pt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [pt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [pt_pkg::KIND_W-1:0]      rsp_tuser,
   input logic                           rsp_tlast
);
   import pt_pkg::*;

   // a stalled response holds its payload
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=>
            rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("response changed while stalled");

   // absent reports never close a request, every other kind does
   property p_last_kind;
      @(posedge clock) disable iff (reset)
         rsp_tvalid |-> (rsp_tlast == (rsp_tuser != KIND_ABSENT));
   endproperty
   a_last_kind: assert property (p_last_kind) else $error("tlast does not fit the kind");

   // the done response carries no id
   property p_done_id;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && (rsp_tuser == KIND_DONE) |-> (rsp_tdata == '0);
   endproperty
   a_done_id: assert property (p_done_id) else $error("done response with nonzero id");

   // a check request blocks the request side while the row is walked
   property p_check_busy;
      @(posedge clock) disable iff (reset)
         req_tvalid && req_tready && (req_tuser == OP_CHECK) |=> !req_tready;
   endproperty
   a_check_busy: assert property (p_check_busy) else $error("request taken during a check");

endmodule

bind presence_table_with_aging pt_checker u_pt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
